// ===== hw/rtl/rf_pulse_width_code_decoder_defines.svh =====
// Assertion macros for the pulse-width code decoder.
// Used by rfpwd_outq in hw/rtl; no other dependencies.
`ifndef RF_PULSE_WIDTH_CODE_DECODER_DEFINES_SVH
`define RF_PULSE_WIDTH_CODE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define RFPWD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define RFPWD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RFPWD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RFPWD_ASSERT(lbl, clk, rstn, prop)
`define RFPWD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RFPWD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/rfpwd_pkg.sv =====
// Shared constants and types of the pulse-width code decoder.
// No dependencies.
package rfpwd_pkg;

    localparam int CODE_BITS   = 24;
    localparam int REPEAT_BITS = 16;
    localparam int STAMP_BITS  = 32;
    localparam int CFG_BITS    = 16;
    localparam int TMO_BITS    = 10;
    localparam int BPOS_BITS   = $clog2(CODE_BITS + 1);

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_SYNC_GAP_MIN   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_START_HIGH_MIN = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PULSE_MIN      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_PULSE_MAX      = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_ONE_WIDTH_LIM  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_TIMEOUT_TICKS  = 3'd5;

    localparam logic [CFG_BITS-1:0] SYNC_GAP_MIN_RST   = 16'd800;
    localparam logic [CFG_BITS-1:0] START_HIGH_MIN_RST = 16'd320;
    localparam logic [CFG_BITS-1:0] PULSE_MIN_RST      = 16'd100;
    localparam logic [CFG_BITS-1:0] PULSE_MAX_RST      = 16'd600;
    localparam logic [CFG_BITS-1:0] ONE_WIDTH_LIM_RST  = 16'd200;
    localparam logic [TMO_BITS-1:0] TIMEOUT_TICKS_RST  = 10'd100;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QA_BITS = $clog2(QDEPTH);
    localparam int QC_BITS = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CFG_BITS-1:0] sync_gap_min;
        logic [CFG_BITS-1:0] start_high_min;
        logic [CFG_BITS-1:0] pulse_min;
        logic [CFG_BITS-1:0] pulse_max;
        logic [CFG_BITS-1:0] one_width_limit;
        logic [TMO_BITS-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [CODE_BITS-1:0]   code_word;
        logic [REPEAT_BITS-1:0] repeat_count;
        logic                   last;
    } t_rec;

    // records made by one item: cnt of 0, 1 or 2, rec0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

endpackage

// ===== hw/rtl/rfpwd_ifs.sv =====
// Valid/ready channel interfaces for input items and result records.
// Depends on rfpwd_pkg.
interface rfpwd_in_if;
    import rfpwd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [STAMP_BITS-1:0] stamp_us;
    logic                  pin_level;
    modport source (output valid, kind, stamp_us, pin_level, input ready);
    modport sink   (input valid, kind, stamp_us, pin_level, output ready);
endinterface

interface rfpwd_out_if;
    import rfpwd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CODE_BITS-1:0]   code_word;
    logic [REPEAT_BITS-1:0] repeat_count;
    logic                   last;
    modport source (output valid, code_word, repeat_count, last, input ready);
    modport sink   (input valid, code_word, repeat_count, last, output ready);
endinterface

// ===== hw/rtl/rf_pulse_width_code_decoder.sv =====
// Pulse-width code decoder: an item enters the input register, is decoded
// combinationally and its records (0 to 2) enter a 4-entry queue as the item
// leaves the register. The item waits there while the queue lacks room: one
// item per cycle while the queue holds at most two records. Records leave one
// per cycle while the output channel is ready.
// Reset is synchronous and active low; no clearing pass.
module rf_pulse_width_code_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rfpwd_in_if.sink                            i_in,
    rfpwd_out_if.source                         o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rfpwd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [rfpwd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [rfpwd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready
);
    import rfpwd_pkg::*;

    t_cfg  cfg;
    t_push push;
    logic  room;

    rfpwd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rfpwd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_room  (room),
        .o_push  (push)
    );

    rfpwd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/rfpwd_regs.sv =====
// APB configuration registers of the pulse-width code decoder.
// Depends on rfpwd_pkg.
module rfpwd_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rfpwd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [rfpwd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [rfpwd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready,
    output rfpwd_pkg::t_cfg                     o_cfg
);
    import rfpwd_pkg::*;

    t_cfg r_cfg;
    logic [REG_IDX_BITS-1:0] idx;
    logic wr_en;

    assign idx    = paddr[APB_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_gap_min    <= SYNC_GAP_MIN_RST;
            r_cfg.start_high_min  <= START_HIGH_MIN_RST;
            r_cfg.pulse_min       <= PULSE_MIN_RST;
            r_cfg.pulse_max       <= PULSE_MAX_RST;
            r_cfg.one_width_limit <= ONE_WIDTH_LIM_RST;
            r_cfg.timeout_ticks   <= TIMEOUT_TICKS_RST;
        end else if (wr_en) begin
            case (idx)
                REG_SYNC_GAP_MIN:   r_cfg.sync_gap_min    <= pwdata[CFG_BITS-1:0];
                REG_START_HIGH_MIN: r_cfg.start_high_min  <= pwdata[CFG_BITS-1:0];
                REG_PULSE_MIN:      r_cfg.pulse_min       <= pwdata[CFG_BITS-1:0];
                REG_PULSE_MAX:      r_cfg.pulse_max       <= pwdata[CFG_BITS-1:0];
                REG_ONE_WIDTH_LIM:  r_cfg.one_width_limit <= pwdata[CFG_BITS-1:0];
                REG_TIMEOUT_TICKS:  r_cfg.timeout_ticks   <= pwdata[TMO_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SYNC_GAP_MIN:   prdata = APB_DATA_BITS'(r_cfg.sync_gap_min);
            REG_START_HIGH_MIN: prdata = APB_DATA_BITS'(r_cfg.start_high_min);
            REG_PULSE_MIN:      prdata = APB_DATA_BITS'(r_cfg.pulse_min);
            REG_PULSE_MAX:      prdata = APB_DATA_BITS'(r_cfg.pulse_max);
            REG_ONE_WIDTH_LIM:  prdata = APB_DATA_BITS'(r_cfg.one_width_limit);
            REG_TIMEOUT_TICKS:  prdata = APB_DATA_BITS'(r_cfg.timeout_ticks);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/rfpwd_core.sv =====
// Input register and decode state of the pulse-width code decoder; makes
// up to two records per item. Depends on rfpwd_pkg and rfpwd_ifs.
module rfpwd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rfpwd_in_if.sink          i_in,
    input  rfpwd_pkg::t_cfg   i_cfg,
    input  logic              i_room,
    output rfpwd_pkg::t_push  o_push
);
    import rfpwd_pkg::*;

    // input register
    logic                  r_in_vld;
    logic                  r_kind;
    logic [STAMP_BITS-1:0] r_stamp;
    logic                  r_pin;

    // decode state
    logic                   r_receiving, n_receiving;
    logic                   r_line_high, n_line_high;
    logic [BPOS_BITS-1:0]   r_bit_pos,   n_bit_pos;
    logic [CODE_BITS-1:0]   r_shift,     n_shift;
    logic [STAMP_BITS-1:0]  r_prev,      n_prev;
    logic [CODE_BITS-1:0]   r_pend_code, n_pend_code;
    logic [REPEAT_BITS-1:0] r_pend_reps, n_pend_reps;
    logic [TMO_BITS-1:0]    r_tmo_left,  n_tmo_left;
    logic                   r_tmo_armed, n_tmo_armed;

    logic                  fire;
    logic [STAMP_BITS-1:0] gap;
    logic                  lh;
    logic [CODE_BITS-1:0]  code;
    t_push                 push;

    assign fire       = r_in_vld && i_room;
    assign i_in.ready = !r_in_vld || fire;
    assign gap        = r_stamp - r_prev;
    assign lh         = !r_line_high;
    assign code       = {r_shift[CODE_BITS-2:0], (gap < STAMP_BITS'(i_cfg.one_width_limit))};
    assign o_push     = push;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind  <= i_in.kind;
            r_stamp <= i_in.stamp_us;
            r_pin   <= i_in.pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_receiving <= 1'b0;
            r_line_high <= 1'b0;
            r_bit_pos   <= '0;
            r_shift     <= '0;
            r_prev      <= '0;
            r_pend_code <= '0;
            r_pend_reps <= '0;
            r_tmo_left  <= TIMEOUT_TICKS_RST;
            r_tmo_armed <= 1'b1;
        end else begin
            if (i_in.ready) r_in_vld <= i_in.valid;
            r_receiving <= n_receiving;
            r_line_high <= n_line_high;
            r_bit_pos   <= n_bit_pos;
            r_shift     <= n_shift;
            r_prev      <= n_prev;
            r_pend_code <= n_pend_code;
            r_pend_reps <= n_pend_reps;
            r_tmo_left  <= n_tmo_left;
            r_tmo_armed <= n_tmo_armed;
        end
    end

    always_comb begin
        n_receiving = r_receiving;
        n_line_high = r_line_high;
        n_bit_pos   = r_bit_pos;
        n_shift     = r_shift;
        n_prev      = r_prev;
        n_pend_code = r_pend_code;
        n_pend_reps = r_pend_reps;
        n_tmo_left  = r_tmo_left;
        n_tmo_armed = r_tmo_armed;
        push.cnt    = 2'd0;
        push.rec0   = '{code_word: r_pend_code, repeat_count: r_pend_reps, last: 1'b0};
        push.rec1   = '{code_word: code, repeat_count: '0, last: 1'b0};

        if (fire) begin
            if (r_kind == KIND_TICK) begin
                if (r_tmo_armed) begin
                    if (r_tmo_left <= TMO_BITS'(1)) begin
                        n_tmo_left  = '0;
                        n_tmo_armed = 1'b0;
                        if (r_pend_reps != '0) begin
                            push.cnt    = 2'd1;
                            n_pend_code = '0;
                            n_pend_reps = '0;
                        end
                    end else begin
                        n_tmo_left = r_tmo_left - TMO_BITS'(1);
                    end
                end
            end else begin
                n_prev      = r_stamp;
                n_line_high = lh;
                if (gap > STAMP_BITS'(i_cfg.sync_gap_min)) begin
                    if (r_receiving) begin
                        if (r_pend_reps != '0) begin
                            push.cnt    = 2'd1;
                            n_pend_code = '0;
                            n_pend_reps = '0;
                        end
                        n_bit_pos = '0;
                    end else if (r_pin) begin
                        n_line_high = 1'b1;
                        n_receiving = 1'b1;
                        n_bit_pos   = '0;
                    end
                end else if (r_receiving) begin
                    // out-of-range pulse still decodes below
                    if (gap < STAMP_BITS'(i_cfg.pulse_min) ||
                        gap > STAMP_BITS'(i_cfg.pulse_max)) begin
                        n_receiving = 1'b0;
                    end
                    if (!lh) begin
                        if (gap >= STAMP_BITS'(i_cfg.start_high_min)) begin
                            n_bit_pos = BPOS_BITS'(1);
                            n_shift   = '0;
                        end else if (r_bit_pos != '0) begin
                            n_shift = code;
                            if (r_bit_pos >= BPOS_BITS'(CODE_BITS)) begin
                                n_bit_pos   = '0;
                                n_tmo_left  = i_cfg.timeout_ticks;
                                n_tmo_armed = 1'b1;
                                if (r_pend_reps != '0 && code == r_pend_code) begin
                                    if (r_pend_reps != '1)
                                        n_pend_reps = r_pend_reps + REPEAT_BITS'(1);
                                end else begin
                                    // flush the old record, then the start record
                                    if (r_pend_reps != '0) begin
                                        push.cnt = 2'd2;
                                    end else begin
                                        push.cnt  = 2'd1;
                                        push.rec0 = push.rec1;
                                    end
                                    n_pend_code = code;
                                    n_pend_reps = REPEAT_BITS'(1);
                                end
                            end else begin
                                n_bit_pos = r_bit_pos + BPOS_BITS'(1);
                            end
                        end
                    end
                end
            end
        end

        if (push.cnt == 2'd1) push.rec0.last = 1'b1;
        if (push.cnt == 2'd2) push.rec1.last = 1'b1;
    end

endmodule

// ===== hw/rtl/rfpwd_outq.sv =====
// Four-entry record queue between the decode core and the output channel.
// Depends on rfpwd_pkg, rfpwd_ifs and the assertion macro header.
`include "rf_pulse_width_code_decoder_defines.svh"
module rfpwd_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfpwd_pkg::t_push  i_push,
    output logic              o_room,
    rfpwd_out_if.source       o_out
);
    import rfpwd_pkg::*;

    t_rec                r_mem [QDEPTH];
    logic [QA_BITS-1:0]  r_wr, r_rd;
    logic [QC_BITS-1:0]  r_cnt, n_cnt;
    logic                pop;
    logic [QA_BITS-1:0]  wr1;
    t_rec                head;

    assign head               = r_mem[r_rd];
    assign o_out.valid        = (r_cnt != '0);
    assign o_out.code_word    = head.code_word;
    assign o_out.repeat_count = head.repeat_count;
    assign o_out.last         = head.last;
    assign pop                = o_out.valid && o_out.ready;
    assign wr1                = r_wr + QA_BITS'(1);
    // room for the worst case of one item
    assign o_room             = (r_cnt <= QC_BITS'(QDEPTH - 2));
    assign n_cnt              = r_cnt + QC_BITS'(i_push.cnt) - QC_BITS'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.rec0;
        if (i_push.cnt == 2'd2) r_mem[wr1]  <= i_push.rec1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QA_BITS'(i_push.cnt);
            if (pop) r_rd <= r_rd + QA_BITS'(1);
            r_cnt <= n_cnt;
        end
    end

    `RFPWD_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= QC_BITS'(QDEPTH))
    `RFPWD_ASSERT(a_push_fits, i_clk, i_rst_n, r_cnt + QC_BITS'(i_push.cnt) <= QC_BITS'(QDEPTH))
    `RFPWD_ASSERT_IMP(a_last_one, i_clk, i_rst_n, i_push.cnt == 2'd1, i_push.rec0.last)
    `RFPWD_ASSERT_IMP(a_last_two, i_clk, i_rst_n, i_push.cnt == 2'd2, i_push.rec1.last && !i_push.rec0.last)
    `RFPWD_ASSERT_NXT(a_pop_drains, i_clk, i_rst_n, pop && i_push.cnt == 2'd0, r_cnt == $past(r_cnt) - QC_BITS'(1))

endmodule
